@@ hw/rtl/dtq_pkg.sv @@
package dtq_pkg;

    // Default sizes of the queue.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int ID_BITS_DEF     = 16;

    // Fixed field widths on the stream ports.
    localparam int OPCODE_BITS    = 2;
    localparam int ARG_BITS       = 32;
    localparam int CANCEL_ID_BITS = 16;
    localparam int KIND_BITS      = 3;
    localparam int ENTRY_ID_BITS  = 16;
    localparam int OCC_BITS       = 5;
    localparam int S_TDATA_BITS   = 80;
    localparam int M_TDATA_BITS   = 24;

    // Input opcodes, carried in tuser.
    localparam logic [OPCODE_BITS-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_CANCEL = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_TICK   = 2'd2;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] K_ADDED     = 3'd0;
    localparam logic [KIND_BITS-1:0] K_FIRED     = 3'd1;
    localparam logic [KIND_BITS-1:0] K_CANCELLED = 3'd2;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN   = 3'd3;
    localparam logic [KIND_BITS-1:0] K_FULL      = 3'd4;
    localparam logic [KIND_BITS-1:0] K_IDLE      = 3'd5;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic shift_all;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/dtq_cell.sv @@
module dtq_cell #(
    parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF
) (
    input  logic                               i_clk,
    input  dtq_pkg::t_cell_ctrl                i_ctrl,
    input  logic                               i_in_range,
    input  logic [TIME_BITS-1:0]               i_key,
    input  logic [ID_BITS-1:0]                 i_new_id,
    input  logic [dtq_pkg::CANCEL_ID_BITS-1:0] i_want,
    input  logic [TIME_BITS-1:0]               i_prev_dl,
    input  logic [ID_BITS-1:0]                 i_prev_id,
    input  logic                               i_prev_keep,
    input  logic [TIME_BITS-1:0]               i_next_dl,
    input  logic [ID_BITS-1:0]                 i_next_id,
    input  logic                               i_found_in,
    output logic [TIME_BITS-1:0]               o_dl,
    output logic [ID_BITS-1:0]                 o_id,
    output logic                               o_keep,
    output logic                               o_found
);

    localparam int CMP_BITS = (ID_BITS > dtq_pkg::CANCEL_ID_BITS) ?
                              ID_BITS : dtq_pkg::CANCEL_ID_BITS;

    logic [TIME_BITS-1:0] r_dl;
    logic [ID_BITS-1:0]   r_id;
    logic                 w_match;

    // The row is sorted, so the cells that keep their place on an insert
    // form an unbroken run from the head.
    assign o_keep  = i_in_range && (r_dl <= i_key);
    assign w_match = i_in_range && (CMP_BITS'(r_id) == CMP_BITS'(i_want));
    assign o_found = i_ctrl.shift_all || i_found_in || w_match;
    assign o_dl    = r_dl;
    assign o_id    = r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_insert && !o_keep) begin
            if (i_prev_keep) begin
                r_dl <= i_key;
                r_id <= i_new_id;
            end else begin
                r_dl <= i_prev_dl;
                r_id <= i_prev_id;
            end
        end else if (i_ctrl.do_remove && o_found) begin
            r_dl <= i_next_dl;
            r_id <= i_next_id;
        end
    end

endmodule

@@ hw/rtl/deadline_timer_queue.sv @@
// Sorted deadline queue. Each input transaction carries an opcode in tuser: add an entry
// that expires delay ms from now, cancel an entry by id, or advance time by elapsed ms.
// Entries sit in a row of cells ordered by deadline, equal deadlines in insertion order.
// An add, a cancel, an idle tick or a refused add moves the block into its operate state,
// which registers its single result, and the block takes the next transaction once that
// result is registered. A tick that fires n entries gives n results, since the head cell
// releases one entry per cycle unless the result output stalls, which holds the block.
// Time and deadlines saturate at the largest TIME_BITS value. Ids skip zero.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // delay [31:0], cancel_id [47:32], elapsed [79:48]
    input  logic [dtq_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // opcode [1:0]
    input  logic [dtq_pkg::OPCODE_BITS-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // kind [2:0], entry_id [18:3], occupancy [23:19]
    output logic [dtq_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_OPER = 1'b1;

    logic [0:0]                          r_state, n_state;
    logic [dtq_pkg::OPCODE_BITS-1:0]     r_op;
    logic [dtq_pkg::CANCEL_ID_BITS-1:0]  r_want;
    logic [TIME_BITS-1:0]                r_key;
    logic [TIME_BITS-1:0]                r_now;
    logic [ID_BITS-1:0]                  r_next_id, n_next_id;
    logic [CNT_BITS-1:0]                 r_count, n_count;

    logic                                r_ov;
    logic [dtq_pkg::KIND_BITS-1:0]       r_kind, n_kind;
    logic [dtq_pkg::ENTRY_ID_BITS-1:0]   r_oid, n_oid;
    logic [dtq_pkg::OCC_BITS-1:0]        r_occ;
    logic                                r_last, n_last;

    logic                                w_in_acc;
    logic                                w_slot;
    logic                                w_load;
    logic [dtq_pkg::ARG_BITS-1:0]        w_arg;
    logic [TIME_BITS:0]                  w_sum;
    logic [TIME_BITS-1:0]                w_sat;
    logic [ID_BITS-1:0]                  w_id_inc;
    dtq_pkg::t_cell_ctrl                 w_ctrl;

    logic [TIME_BITS-1:0] w_dl      [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   w_id      [QUEUE_DEPTH];
    logic                 w_keep    [QUEUE_DEPTH];
    logic                 w_found   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] w_prev_dl [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   w_prev_id [QUEUE_DEPTH];
    logic                 w_prev_kp [QUEUE_DEPTH];
    logic                 w_fnd_in  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] w_next_dl [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   w_next_id [QUEUE_DEPTH];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot        = !r_ov || m_axis_tready;

    // The same saturating adder stamps a new deadline or advances the time.
    assign w_arg = (s_axis_tuser == dtq_pkg::OP_TICK) ? s_axis_tdata[79:48]
                                                      : s_axis_tdata[31:0];
    assign w_sum = {1'b0, r_now} + (TIME_BITS + 1)'(w_arg);
    assign w_sat = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];

    assign w_id_inc = r_next_id + ID_BITS'(1);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_prev_dl[gi] = '0;
                assign w_prev_id[gi] = '0;
                assign w_prev_kp[gi] = 1'b1;
                assign w_fnd_in[gi]  = 1'b0;
            end else begin : g_body
                assign w_prev_dl[gi] = w_dl[gi-1];
                assign w_prev_id[gi] = w_id[gi-1];
                assign w_prev_kp[gi] = w_keep[gi-1];
                assign w_fnd_in[gi]  = w_found[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next_dl[gi] = w_dl[gi];
                assign w_next_id[gi] = w_id[gi];
            end else begin : g_inner
                assign w_next_dl[gi] = w_dl[gi+1];
                assign w_next_id[gi] = w_id[gi+1];
            end

            dtq_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_in_range  (r_count > CNT_BITS'(gi)),
                .i_key       (r_key),
                .i_new_id    (r_next_id),
                .i_want      (r_want),
                .i_prev_dl   (w_prev_dl[gi]),
                .i_prev_id   (w_prev_id[gi]),
                .i_prev_keep (w_prev_kp[gi]),
                .i_next_dl   (w_next_dl[gi]),
                .i_next_id   (w_next_id[gi]),
                .i_found_in  (w_fnd_in[gi]),
                .o_dl        (w_dl[gi]),
                .o_id        (w_id[gi]),
                .o_keep      (w_keep[gi]),
                .o_found     (w_found[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_next_id = r_next_id;
        n_count   = r_count;
        n_kind    = dtq_pkg::K_IDLE;
        n_oid     = '0;
        n_last    = 1'b1;
        w_load    = 1'b0;
        w_ctrl    = '0;
        if (r_state == ST_OPER) begin
            unique case (r_op)
                dtq_pkg::OP_ADD: begin
                    if (w_slot) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                        if (r_count >= CNT_BITS'(QUEUE_DEPTH)) begin
                            n_kind = dtq_pkg::K_FULL;
                        end else begin
                            w_ctrl.do_insert = 1'b1;
                            n_kind    = dtq_pkg::K_ADDED;
                            n_oid     = dtq_pkg::ENTRY_ID_BITS'(r_next_id);
                            n_count   = r_count + CNT_BITS'(1);
                            n_next_id = (w_id_inc == '0) ? ID_BITS'(1) : w_id_inc;
                        end
                    end
                end
                dtq_pkg::OP_CANCEL: begin
                    if (w_slot) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                        if (w_found[QUEUE_DEPTH-1]) begin
                            w_ctrl.do_remove = 1'b1;
                            n_kind  = dtq_pkg::K_CANCELLED;
                            n_oid   = r_want;
                            n_count = r_count - CNT_BITS'(1);
                        end else begin
                            n_kind = dtq_pkg::K_UNKNOWN;
                        end
                    end
                end
                dtq_pkg::OP_TICK: begin
                    if (w_slot) begin
                        w_load = 1'b1;
                        if (w_keep[0]) begin
                            // The head expired: shift the whole row by one. The result
                            // is last when the entry behind it has not expired.
                            w_ctrl.do_remove = 1'b1;
                            w_ctrl.shift_all = 1'b1;
                            n_kind  = dtq_pkg::K_FIRED;
                            n_oid   = dtq_pkg::ENTRY_ID_BITS'(w_id[0]);
                            n_count = r_count - CNT_BITS'(1);
                            n_last  = !w_keep[1];
                            if (!w_keep[1]) begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_kind  = dtq_pkg::K_IDLE;
                            n_state = ST_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_next_id <= ID_BITS'(1);
            r_count   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= w_in_acc ? ST_OPER : n_state;
            r_next_id <= n_next_id;
            r_count   <= n_count;
            if (w_in_acc && (s_axis_tuser == dtq_pkg::OP_TICK)) begin
                r_now <= w_sat;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= s_axis_tuser;
            r_want <= s_axis_tdata[47:32];
            r_key  <= w_sat;
        end
        if (w_load) begin
            r_kind <= n_kind;
            r_oid  <= n_oid;
            r_occ  <= dtq_pkg::OCC_BITS'(n_count);
            r_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_occ, r_oid, r_kind};
    assign m_axis_tlast  = r_last;

endmodule

@@ hw/rtl/dtq_checker.sv @@
module dtq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dtq_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    logic [dtq_pkg::KIND_BITS-1:0] w_kind;

    assign w_kind = m_axis_tdata[2:0];

    // A result waiting on the output stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Every kind other than fired ends its transaction at once.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_kind != dtq_pkg::K_FIRED)) |-> m_axis_tlast)
        else $error("single result without tlast");

    // While a tick is still firing entries, no new transaction is taken.
    a_busy_firing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted during a run of fired results");

    // One transaction at a time: the input closes right after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an acceptance");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
